@@ sv/dts_pkg.sv @@
// Package for the Datalog token scanner: widths, token and mode codes, character
// codes, keyword tables and the small helper functions used by the step logic.
// No dependencies.
`default_nettype none

package dts_pkg;

  localparam int LINE_WIDTH   = 24;
  localparam int LENGTH_WIDTH = 16;
  localparam int KIND_WIDTH   = 5;
  localparam int CHAR_WIDTH   = 8;
  localparam int NUM_KW       = 4;
  localparam int KW_SLOTS     = 8;

  // Output stream payload: kind, start line, length, padded to whole bytes.
  localparam int OUT_FIELDS_WIDTH = KIND_WIDTH + LINE_WIDTH + LENGTH_WIDTH;
  localparam int OUT_TDATA_WIDTH  = ((OUT_FIELDS_WIDTH + 7) / 8) * 8;
  localparam int OUT_PAD_WIDTH    = OUT_TDATA_WIDTH - OUT_FIELDS_WIDTH;

  // Result queue between the step logic and the output port.
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCOUNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [KIND_WIDTH-1:0] {
    TK_COMMA     = 5'd0,
    TK_PERIOD    = 5'd1,
    TK_QMARK     = 5'd2,
    TK_LPAREN    = 5'd3,
    TK_RPAREN    = 5'd4,
    TK_COLON     = 5'd5,
    TK_COLONDASH = 5'd6,
    TK_MUL       = 5'd7,
    TK_ADD       = 5'd8,
    TK_SCHEMES   = 5'd9,
    TK_FACTS     = 5'd10,
    TK_RULES     = 5'd11,
    TK_QUERIES   = 5'd12,
    TK_ID        = 5'd13,
    TK_STRING    = 5'd14,
    TK_UNDEF     = 5'd15,
    TK_END       = 5'd16
  } token_kind_t;

  typedef enum logic [3:0] {
    M_IDLE,
    M_IDENT,
    M_COLON,
    M_HASH,
    M_LINECOM,
    M_BLOCK,
    M_BLOCKBAR,
    M_STRING,
    M_STRQUOTE
  } scan_mode_t;

  typedef struct packed {
    scan_mode_t                mode;
    logic [LINE_WIDTH-1:0]     line_count;
    logic [LINE_WIDTH-1:0]     token_line;
    logic [LENGTH_WIDTH-1:0]   token_len;
    logic [NUM_KW-1:0]         keyword_hits;
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{
    mode:         M_IDLE,
    line_count:   LINE_WIDTH'(1),
    token_line:   LINE_WIDTH'(1),
    token_len:    '0,
    keyword_hits: '1
  };

  typedef struct packed {
    logic                    valid;
    token_kind_t             kind;
    logic [LINE_WIDTH-1:0]   line;
    logic [LENGTH_WIDTH-1:0] len;
  } dts_result_t;

  typedef struct packed {
    logic [LENGTH_WIDTH-1:0] len;
    logic [LINE_WIDTH-1:0]   line;
    token_kind_t             kind;
    logic                    last;
  } out_entry_t;

  localparam logic [CHAR_WIDTH-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_WIDTH-1:0] CH_NL    = 8'h0A;
  localparam logic [CHAR_WIDTH-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_WIDTH-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_WIDTH-1:0] CH_HASH  = 8'h23;
  localparam logic [CHAR_WIDTH-1:0] CH_QUOTE = 8'h27;
  localparam logic [CHAR_WIDTH-1:0] CH_LPAR  = 8'h28;
  localparam logic [CHAR_WIDTH-1:0] CH_RPAR  = 8'h29;
  localparam logic [CHAR_WIDTH-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_WIDTH-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_WIDTH-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_WIDTH-1:0] CH_DASH  = 8'h2D;
  localparam logic [CHAR_WIDTH-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_WIDTH-1:0] CH_COLON = 8'h3A;
  localparam logic [CHAR_WIDTH-1:0] CH_QMARK = 8'h3F;
  localparam logic [CHAR_WIDTH-1:0] CH_BAR   = 8'h7C;

  // Keyword spellings, zero padded to eight bytes.
  localparam logic [CHAR_WIDTH-1:0] KW_TEXT [NUM_KW][KW_SLOTS] = '{
    '{8'h53, 8'h63, 8'h68, 8'h65, 8'h6D, 8'h65, 8'h73, 8'h00},
    '{8'h46, 8'h61, 8'h63, 8'h74, 8'h73, 8'h00, 8'h00, 8'h00},
    '{8'h52, 8'h75, 8'h6C, 8'h65, 8'h73, 8'h00, 8'h00, 8'h00},
    '{8'h51, 8'h75, 8'h65, 8'h72, 8'h69, 8'h65, 8'h73, 8'h00}
  };

  localparam logic [LENGTH_WIDTH-1:0] KW_LEN [NUM_KW] = '{
    LENGTH_WIDTH'(7), LENGTH_WIDTH'(5), LENGTH_WIDTH'(5), LENGTH_WIDTH'(7)
  };

  localparam token_kind_t KW_KIND [NUM_KW] = '{TK_SCHEMES, TK_FACTS, TK_RULES, TK_QUERIES};

  function automatic logic is_alpha(input logic [CHAR_WIDTH-1:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_alnum(input logic [CHAR_WIDTH-1:0] c);
    return is_alpha(c) || (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic logic is_space(input logic [CHAR_WIDTH-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic [LINE_WIDTH-1:0] line_inc(input logic [LINE_WIDTH-1:0] v);
    return (&v) ? v : v + LINE_WIDTH'(1);
  endfunction

  function automatic logic [LENGTH_WIDTH-1:0] len_inc(input logic [LENGTH_WIDTH-1:0] v);
    return (&v) ? v : v + LENGTH_WIDTH'(1);
  endfunction

  // Keeps the bit of each keyword whose spelling still agrees with the identifier.
  function automatic logic [NUM_KW-1:0] kw_match(input logic [NUM_KW-1:0]       hits,
                                                  input logic [LENGTH_WIDTH-1:0] pos,
                                                  input logic [CHAR_WIDTH-1:0]   c);
    logic [NUM_KW-1:0] res;
    res = '0;
    for (int k = 0; k < NUM_KW; k++) begin
      if (hits[k] && pos < KW_LEN[k] && KW_TEXT[k][pos[$clog2(KW_SLOTS)-1:0]] == c) begin
        res[k] = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic token_kind_t ident_kind(input logic [NUM_KW-1:0]       hits,
                                             input logic [LENGTH_WIDTH-1:0] len);
    token_kind_t kind;
    kind = TK_ID;
    for (int k = NUM_KW - 1; k >= 0; k--) begin
      if (hits[k] && len == KW_LEN[k]) begin
        kind = KW_KIND[k];
      end
    end
    return kind;
  endfunction

endpackage

`default_nettype wire

@@ sv/dts_step.sv @@
// Next-state and token logic of the Datalog token scanner for one input byte.
// Purely combinational; depends on dts_pkg.
`default_nettype none

module dts_step (
  input  dts_pkg::scan_state_t           cur,
  input  logic [dts_pkg::CHAR_WIDTH-1:0] char_in,
  input  logic                           end_of_input,
  output dts_pkg::scan_state_t           nxt,
  output dts_pkg::dts_result_t           res_a,
  output dts_pkg::dts_result_t           res_b
);
  import dts_pkg::*;

  scan_state_t idle_st;
  dts_result_t idle_res;

  // What a byte does when no token is pending.
  always_comb begin
    idle_st       = cur;
    idle_st.mode  = M_IDLE;
    idle_res      = '0;
    idle_res.line = cur.line_count;
    idle_res.len  = LENGTH_WIDTH'(1);
    idle_res.kind = TK_UNDEF;
    if (is_space(char_in)) begin
      if (char_in == CH_NL) begin
        idle_st.line_count = line_inc(cur.line_count);
      end
    end else if (is_alpha(char_in)) begin
      idle_st.mode         = M_IDENT;
      idle_st.token_line   = cur.line_count;
      idle_st.token_len    = LENGTH_WIDTH'(1);
      idle_st.keyword_hits = kw_match('1, '0, char_in);
    end else begin
      case (char_in)
        CH_COMMA: begin idle_res.valid = 1'b1; idle_res.kind = TK_COMMA;  end
        CH_DOT:   begin idle_res.valid = 1'b1; idle_res.kind = TK_PERIOD; end
        CH_QMARK: begin idle_res.valid = 1'b1; idle_res.kind = TK_QMARK;  end
        CH_LPAR:  begin idle_res.valid = 1'b1; idle_res.kind = TK_LPAREN; end
        CH_RPAR:  begin idle_res.valid = 1'b1; idle_res.kind = TK_RPAREN; end
        CH_STAR:  begin idle_res.valid = 1'b1; idle_res.kind = TK_MUL;    end
        CH_PLUS:  begin idle_res.valid = 1'b1; idle_res.kind = TK_ADD;    end
        CH_COLON: begin
          idle_st.mode       = M_COLON;
          idle_st.token_line = cur.line_count;
          idle_st.token_len  = LENGTH_WIDTH'(1);
        end
        CH_HASH: begin
          idle_st.mode       = M_HASH;
          idle_st.token_line = cur.line_count;
          idle_st.token_len  = LENGTH_WIDTH'(1);
        end
        CH_QUOTE: begin
          idle_st.mode       = M_STRING;
          idle_st.token_line = cur.line_count;
          idle_st.token_len  = LENGTH_WIDTH'(1);
        end
        default: begin
          idle_res.valid = 1'b1;
          idle_res.kind  = TK_UNDEF;
        end
      endcase
    end
  end

  // The pending token, if any, goes out first; a byte's own token goes second.
  always_comb begin
    nxt         = cur;
    res_a       = '0;
    res_a.kind  = TK_UNDEF;
    res_a.line  = cur.token_line;
    res_a.len   = cur.token_len;
    res_b       = idle_res;
    res_b.valid = 1'b0;
    if (end_of_input) begin
      case (cur.mode)
        M_IDENT: begin
          res_a.valid = 1'b1;
          res_a.kind  = ident_kind(cur.keyword_hits, cur.token_len);
        end
        M_COLON: begin
          res_a.valid = 1'b1;
          res_a.kind  = TK_COLON;
        end
        M_BLOCK, M_BLOCKBAR, M_STRING: begin
          res_a.valid = 1'b1;
          res_a.kind  = TK_UNDEF;
        end
        M_STRQUOTE: begin
          res_a.valid = 1'b1;
          res_a.kind  = TK_STRING;
        end
        default: begin
          res_a.valid = 1'b0;
        end
      endcase
      res_b.valid = 1'b1;
      res_b.kind  = TK_END;
      res_b.line  = cur.line_count;
      res_b.len   = '0;
      nxt         = SCAN_RESET;
    end else begin
      case (cur.mode)
        M_IDENT: begin
          if (is_alnum(char_in)) begin
            nxt.keyword_hits = kw_match(cur.keyword_hits, cur.token_len, char_in);
            nxt.token_len    = len_inc(cur.token_len);
          end else begin
            res_a.valid = 1'b1;
            res_a.kind  = ident_kind(cur.keyword_hits, cur.token_len);
            nxt         = idle_st;
            res_b       = idle_res;
          end
        end
        M_COLON: begin
          res_a.valid = 1'b1;
          if (char_in == CH_DASH) begin
            res_a.kind = TK_COLONDASH;
            res_a.len  = LENGTH_WIDTH'(2);
            nxt.mode   = M_IDLE;
          end else begin
            res_a.kind = TK_COLON;
            nxt        = idle_st;
            res_b      = idle_res;
          end
        end
        M_HASH: begin
          if (char_in == CH_BAR) begin
            nxt.mode      = M_BLOCK;
            nxt.token_len = LENGTH_WIDTH'(2);
          end else if (char_in == CH_NL) begin
            nxt.mode       = M_IDLE;
            nxt.line_count = line_inc(cur.line_count);
          end else begin
            nxt.mode = M_LINECOM;
          end
        end
        M_LINECOM: begin
          if (char_in == CH_NL) begin
            nxt.mode       = M_IDLE;
            nxt.line_count = line_inc(cur.line_count);
          end
        end
        M_BLOCK, M_BLOCKBAR: begin
          nxt.token_len = len_inc(cur.token_len);
          if (cur.mode == M_BLOCKBAR && char_in == CH_HASH) begin
            nxt.mode = M_IDLE;
          end else begin
            if (char_in == CH_NL) begin
              nxt.line_count = line_inc(cur.line_count);
            end
            nxt.mode = (char_in == CH_BAR) ? M_BLOCKBAR : M_BLOCK;
          end
        end
        M_STRING: begin
          nxt.token_len = len_inc(cur.token_len);
          if (char_in == CH_NL) begin
            nxt.line_count = line_inc(cur.line_count);
          end
          if (char_in == CH_QUOTE) begin
            nxt.mode = M_STRQUOTE;
          end
        end
        M_STRQUOTE: begin
          if (char_in == CH_QUOTE) begin
            nxt.token_len = len_inc(cur.token_len);
            nxt.mode      = M_STRING;
          end else begin
            res_a.valid = 1'b1;
            res_a.kind  = TK_STRING;
            nxt         = idle_st;
            res_b       = idle_res;
          end
        end
        default: begin
          nxt   = idle_st;
          res_b = idle_res;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ sv/datalog_token_scanner.sv @@
// Top level of the Datalog token scanner: scanner state register, step logic and
// a four-entry result queue in front of the output stream. Depends on dts_pkg, dts_step.
// The first token caused by a byte is offered on m_axis in the cycle after its transfer
// when no older token waits in the result queue. Throughput: one byte per cycle; a byte
// may cause two tokens, and while m_axis_tready is high the output drains one token per
// cycle, so s_axis_tready drops whenever the result queue has room for fewer than two
// tokens. Reset (rst, synchronous): line 1, no token pending, queue empty.
`default_nettype none

module datalog_token_scanner (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [dts_pkg::CHAR_WIDTH-1:0]       s_axis_tdata,  // [7:0] char_in
  input  logic                                 s_axis_tlast,  // end_of_input
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [4:0] token_kind, [28:5] start_line, [44:29] lexeme_length, [47:45] zero
  output logic [dts_pkg::OUT_TDATA_WIDTH-1:0]  m_axis_tdata,
  output logic                                 m_axis_tlast   // last_of_run
);
  import dts_pkg::*;

  scan_state_t             state;
  scan_state_t             state_next;
  dts_result_t             res_a;
  dts_result_t             res_b;
  out_entry_t              queue [QDEPTH];
  logic [QPTR_W-1:0]       wr_ptr;
  logic [QPTR_W-1:0]       rd_ptr;
  logic [QCOUNT_W-1:0]     count;
  logic                    in_xfer;
  logic                    out_xfer;
  logic [1:0]              push_n;
  out_entry_t              first;
  out_entry_t              second;
  out_entry_t              head;

  dts_step u_step (
    .cur          (state),
    .char_in      (s_axis_tdata),
    .end_of_input (s_axis_tlast),
    .nxt          (state_next),
    .res_a        (res_a),
    .res_b        (res_b)
  );

  assign s_axis_tready = (count <= QCOUNT_W'(QDEPTH - 2));
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (count != '0);
  assign out_xfer      = m_axis_tvalid && m_axis_tready;

  always_comb begin
    push_n = 2'(res_a.valid) + 2'(res_b.valid);
    if (res_a.valid) begin
      first = '{len: res_a.len, line: res_a.line, kind: res_a.kind, last: !res_b.valid};
    end else begin
      first = '{len: res_b.len, line: res_b.line, kind: res_b.kind, last: 1'b1};
    end
    second = '{len: res_b.len, line: res_b.line, kind: res_b.kind, last: 1'b1};
  end

  assign head         = queue[rd_ptr];
  assign m_axis_tdata = {{OUT_PAD_WIDTH{1'b0}}, head.len, head.line, head.kind};
  assign m_axis_tlast = head.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= SCAN_RESET;
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (in_xfer) begin
        state  <= state_next;
        wr_ptr <= wr_ptr + QPTR_W'(push_n);
      end
      if (out_xfer) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + (in_xfer ? QCOUNT_W'(push_n) : '0) - QCOUNT_W'(out_xfer);
    end
  end

  // Queue payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_xfer && push_n != 2'd0) begin
      queue[wr_ptr] <= first;
      if (push_n == 2'd2) begin
        queue[wr_ptr + QPTR_W'(1)] <= second;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/dts_checker.sv @@
// Port-level checks for the Datalog token scanner, attached by the bind below.
// Depends on dts_pkg and on the port list of datalog_token_scanner.
`default_nettype none

module dts_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic [dts_pkg::CHAR_WIDTH-1:0]      s_axis_tdata,
  input logic                                s_axis_tlast,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [dts_pkg::OUT_TDATA_WIDTH-1:0] m_axis_tdata,
  input logic                                m_axis_tlast
);
  import dts_pkg::*;

  localparam int LINE_LO = KIND_WIDTH;
  localparam int LEN_LO  = KIND_WIDTH + LINE_WIDTH;

  logic [KIND_WIDTH-1:0]   kind;
  logic [LINE_WIDTH-1:0]   line;
  logic [LENGTH_WIDTH-1:0] len;

  assign kind = m_axis_tdata[KIND_WIDTH-1:0];
  assign line = m_axis_tdata[LEN_LO-1:LINE_LO];
  assign len  = m_axis_tdata[LEN_LO+LENGTH_WIDTH-1:LEN_LO];

  // A byte waiting for its transfer is held by the source.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
      (s_axis_tvalid && !s_axis_tready) |=>
      (s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tlast)))
    else $error("input byte changed while waiting");

  // A stalled output transfer keeps its token.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
      (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("output token changed while stalled");

  // END always closes a run and carries no text.
  a_end_last: assert property (@(posedge clk) disable iff (rst)
      (m_axis_tvalid && kind == KIND_WIDTH'(TK_END)) |-> (m_axis_tlast && len == '0))
    else $error("END token without tlast or with a length");

  // Line numbers start at one and saturate, so zero never appears.
  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
      m_axis_tvalid |-> (line != '0))
    else $error("token reported on line zero");

  // The two-byte operator always reports its full length.
  a_colondash_len: assert property (@(posedge clk) disable iff (rst)
      (m_axis_tvalid && kind == KIND_WIDTH'(TK_COLONDASH)) |-> (len == LENGTH_WIDTH'(2)))
    else $error("colon-dash token with wrong length");

endmodule

bind datalog_token_scanner dts_checker u_dts_checker (.*);

`default_nettype wire
